/* sv/nrrs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nrrs_pkg
// Shared constants and types of the nested ring run scanner.
// ----------------------------------------------------------------------------
package nrrs_pkg;

    localparam int MAX_LINE = 4096;
    localparam int POS_W    = $clog2(MAX_LINE + 1);
    localparam int PAT_W    = $clog2(MAX_LINE);
    localparam int RUN_W    = 13;
    localparam int OFS_W    = 12;
    localparam int HIT_W    = 13;
    localparam int SIZE_W   = 11;
    localparam int NUM_W    = 6;
    localparam int DEN_W    = 6;
    localparam int FLIP_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [NUM_W-1:0]  RATIO_NUM_RST  = NUM_W'(18);
    localparam logic [DEN_W-1:0]  RATIO_DEN_RST  = DEN_W'(25);
    localparam logic [FLIP_W-1:0] RING_FLIPS_RST = FLIP_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO_NUM  = 2'd0,
        CFG_RATIO_DEN  = 2'd1,
        CFG_RING_FLIPS = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_LEAD   = 3'd1,
        ST_WHITE  = 3'd2,
        ST_RING_B = 3'd3,
        ST_RING_W = 3'd4,
        ST_FINAL  = 3'd5
    } scan_state_t;

    typedef struct packed {
        logic [NUM_W-1:0]  ratio_num;
        logic [DEN_W-1:0]  ratio_den;
        logic [FLIP_W-1:0] ring_flips;
    } cfg_t;

    typedef struct packed {
        logic             line_start;
        logic             pixel_white;
        logic [OFS_W-1:0] x_offset;
        logic [OFS_W-1:0] y_offset;
        logic             horizontal;
    } pix_item_t;

    typedef struct packed {
        logic              valid;
        logic [HIT_W-1:0]  hit_x;
        logic [HIT_W-1:0]  hit_y;
        logic [SIZE_W-1:0] ring_size;
        logic              hit_horizontal;
    } hit_t;

endpackage
`default_nettype wire

/* sv/nrrs_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nrrs_scan
// Run-length state machine: updates the scan state for one pixel per step
// and forms the hit of that pixel.
// ----------------------------------------------------------------------------
module nrrs_scan
    import nrrs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      step_en,
    input  wire pix_item_t item,
    input  wire cfg_t      cfg,
    output hit_t           hit
);

    scan_state_t       state_reg,      state_next;
    logic [FLIP_W-1:0] flips_reg,      flips_next;
    logic [RUN_W-1:0]  run_cur_reg,    run_cur_next;
    logic [RUN_W-1:0]  run_prev_reg,   run_prev_next;
    logic [PAT_W-1:0]  pat_start_reg,  pat_start_next;
    logic [PAT_W-1:0]  pat_end_reg,    pat_end_next;
    logic [POS_W-1:0]  pos_reg,        pos_next;
    logic              last_white_reg, last_white_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LEAD;
            flips_reg      <= '0;
            run_cur_reg    <= '0;
            run_prev_reg   <= '0;
            pat_start_reg  <= '0;
            pat_end_reg    <= '0;
            pos_reg        <= '0;
            last_white_reg <= 1'b0;
        end else if (step_en) begin
            state_reg      <= state_next;
            flips_reg      <= flips_next;
            run_cur_reg    <= run_cur_next;
            run_prev_reg   <= run_prev_next;
            pat_start_reg  <= pat_start_next;
            pat_end_reg    <= pat_end_next;
            pos_reg        <= pos_next;
            last_white_reg <= last_white_next;
        end
    end

    always_comb begin
        scan_state_t       st;
        logic [FLIP_W-1:0] fl;
        logic [RUN_W-1:0]  rc;
        logic [RUN_W-1:0]  rp;
        logic [PAT_W-1:0]  ps;
        logic [PAT_W-1:0]  pe;
        logic [POS_W-1:0]  i;
        logic [POS_W-1:0]  i_dec;
        logic              lw;
        logic              pw;
        logic [RUN_W-1:0]  mx;
        logic [RUN_W:0]    sum;
        logic [RUN_W+DEN_W:0] lhs;
        logic [RUN_W+NUM_W:0] rhs;
        logic              bal;
        logic              unbal;
        logic [PAT_W-1:0]  half;
        logic [PAT_W-1:0]  center;

        pw = item.pixel_white;
        if (item.line_start) begin
            st = ST_LEAD;
            fl = '0;
            rc = '0;
            rp = '0;
            ps = '0;
            pe = '0;
            i  = '0;
            lw = pw;
        end else begin
            st = state_reg;
            fl = flips_reg;
            rc = run_cur_reg;
            rp = run_prev_reg;
            ps = pat_start_reg;
            pe = pat_end_reg;
            i  = pos_reg;
            lw = last_white_reg;
        end

        if (pw == lw && rc != {RUN_W{1'b1}}) begin
            rc = rc + RUN_W'(1);
        end

        mx    = (rc > rp) ? rc : rp;
        sum   = {1'b0, rc} + {1'b0, rp};
        lhs   = (RUN_W+DEN_W+1)'(mx) * (RUN_W+DEN_W+1)'(cfg.ratio_den);
        rhs   = (RUN_W+NUM_W+1)'(sum) * (RUN_W+NUM_W+1)'(cfg.ratio_num);
        bal   = (sum != '0) && ((RUN_W+NUM_W+1)'(lhs) < rhs);
        unbal = (sum != '0) && !bal;

        i_dec = (i == '0) ? '0 : i - POS_W'(1);

        state_next      = st;
        flips_next      = fl;
        run_cur_next    = rc;
        run_prev_next   = rp;
        pat_start_next  = ps;
        pat_end_next    = pe;
        last_white_next = pw;
        pos_next        = (i < POS_W'(MAX_LINE)) ? i + POS_W'(1) : POS_W'(MAX_LINE);

        half   = (pe >= ps) ? ((pe - ps) >> 1) : '0;
        center = ps + half;

        hit.valid          = 1'b0;
        hit.hit_x          = item.horizontal ? HIT_W'(center) + HIT_W'(item.x_offset)
                                             : HIT_W'(item.x_offset);
        hit.hit_y          = item.horizontal ? HIT_W'(item.y_offset)
                                             : HIT_W'(center) + HIT_W'(item.y_offset);
        hit.ring_size      = SIZE_W'(half);
        hit.hit_horizontal = item.horizontal;

        case (st)
            ST_LEAD: begin
                if (pw) begin
                    state_next     = ST_WHITE;
                    run_prev_next  = rc;
                    run_cur_next   = RUN_W'(1);
                    pat_start_next = (i > POS_W'(MAX_LINE - 1)) ? PAT_W'(MAX_LINE - 1)
                                                                : PAT_W'(i);
                end
            end
            ST_WHITE: begin
                if (!pw) begin
                    if (rc < rp) begin
                        state_next = ST_RING_B;
                        flips_next = FLIP_W'(1);
                    end else begin
                        state_next = ST_LEAD;
                    end
                    run_prev_next = rc;
                    run_cur_next  = RUN_W'(1);
                end
            end
            ST_RING_B: begin
                if (pw) begin
                    run_prev_next = rc;
                    run_cur_next  = RUN_W'(1);
                    if (bal) begin
                        state_next = ST_RING_W;
                        flips_next = fl + FLIP_W'(1);
                    end else begin
                        state_next = ST_WHITE;
                    end
                end else if (rc > rp && unbal) begin
                    state_next = ST_LEAD;
                end
            end
            ST_RING_W: begin
                if (!pw) begin
                    pat_end_next  = (i_dec > POS_W'(MAX_LINE - 1)) ? PAT_W'(MAX_LINE - 1)
                                                                   : PAT_W'(i_dec);
                    run_prev_next = rc;
                    run_cur_next  = RUN_W'(1);
                    if (bal) begin
                        if (fl == cfg.ring_flips) begin
                            state_next = ST_FINAL;
                        end else begin
                            state_next = ST_RING_B;
                            flips_next = fl + FLIP_W'(1);
                        end
                    end else begin
                        state_next = ST_LEAD;
                    end
                end else if (rc > rp && unbal) begin
                    state_next = ST_WHITE;
                end
            end
            ST_FINAL: begin
                if (pw) begin
                    if (rc < rp) begin
                        state_next = ST_LEAD;
                    end else begin
                        hit.valid = 1'b1;
                    end
                end else if (rc > rp && unbal) begin
                    state_next = ST_LEAD;
                end
            end
            default: begin
                state_next = ST_LEAD;
            end
        endcase
    end

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_LINE))
        else $error("pixel position above line limit");

    a_hit_final: assert property (@(posedge aclk) disable iff (!aresetn)
        hit.valid |-> item.pixel_white && !item.line_start && state_reg == ST_FINAL)
        else $error("hit outside final state");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_LEAD |-> run_cur_reg != '0)
        else $error("empty run while inside a pattern");

endmodule
`default_nettype wire

/* sv/nested_ring_run_scanner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nested_ring_run_scanner
// Scans a binary line for the run-length signature of a nested ring marker.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle and keeps that rate under any stall pattern that
// leaves both channels moving. A pixel sits in the input register, the scan
// state machine updates from it, and a hit, if any, lands in the result
// register. While a hit waits to be taken, the input register holds one
// more pixel and the input stalls until the hit leaves. Assert the line
// start flag on the first pixel of each line; hits give the marker center
// plus the offset, half the pattern width and the scan orientation.
// Write the ratio and flip registers only while no pixel is in flight.
// ----------------------------------------------------------------------------
module nested_ring_run_scanner
    import nrrs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,  // pixel_white, x_offset, y_offset
    input  wire logic [1:0]            s_tuser,  // line_start, horizontal

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [39:0]                m_tdata,  // hit_x, hit_y, ring_size
    output logic [0:0]                 m_tuser   // hit_horizontal
);

    cfg_t      cfg_reg;
    logic      in_valid_reg, in_valid_next;
    pix_item_t in_item_reg;
    logic      out_valid_reg, out_valid_next;
    hit_t      out_hit_reg;
    hit_t      scan_hit;
    logic      out_free;
    logic      fire;
    logic      s_take;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ratio_num  <= RATIO_NUM_RST;
            cfg_reg.ratio_den  <= RATIO_DEN_RST;
            cfg_reg.ring_flips <= RING_FLIPS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RATIO_NUM:  cfg_reg.ratio_num  <= NUM_W'(cfg_data);
                CFG_RATIO_DEN:  cfg_reg.ratio_den  <= DEN_W'(cfg_data);
                CFG_RING_FLIPS: cfg_reg.ring_flips <= FLIP_W'(cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_valid_next  = s_take || (in_valid_reg && !fire);
        out_valid_next = fire ? scan_hit.valid : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the item while the result side is stalled
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg.line_start  <= s_tuser[0];
            in_item_reg.pixel_white <= s_tdata[0];
            in_item_reg.x_offset    <= s_tdata[OFS_W:1];
            in_item_reg.y_offset    <= s_tdata[2*OFS_W:OFS_W+1];
            in_item_reg.horizontal  <= s_tuser[1];
        end
        if (fire && scan_hit.valid) begin
            out_hit_reg <= scan_hit;
        end
    end

    nrrs_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (fire),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .hit     (scan_hit)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_hit_reg.ring_size, out_hit_reg.hit_y, out_hit_reg.hit_x};
    assign m_tuser  = out_hit_reg.hit_horizontal;

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while item is stalled");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_item_reg))
        else $error("stalled item lost");

    a_hit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid == $past(scan_hit.valid))
        else $error("hit not registered");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input blocked while empty");

endmodule
`default_nettype wire

/* tb/tb_nested_ring_run_scanner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_nested_ring_run_scanner
// Self-checking bench for the nested ring run scanner.
// ----------------------------------------------------------------------------
// Feeds pixel lines built from run lengths: a few hand-made lines first (no
// line start after reset, offsets at both extremes, both scan orientations),
// then phases of random lines under several ratio and flip settings. Most
// random lines follow the ring signature with jittered runs; the rest are
// broken lines and raw pixel noise. A scoreboard predicts every hit from
// accepted pixels and compares each taken hit field by field. Both channels
// idle at random, and the hit side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_nested_ring_run_scanner;
    import nrrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    class run_hit_scoreboard;
        logic [NUM_W-1:0]  ratio_num;
        logic [DEN_W-1:0]  ratio_den;
        logic [FLIP_W-1:0] ring_flips;

        scan_state_t       state;
        logic [FLIP_W-1:0] flips;
        logic [RUN_W-1:0]  run_cur;
        logic [RUN_W-1:0]  run_prev;
        logic [PAT_W-1:0]  pat_start;
        logic [PAT_W-1:0]  pat_end;
        logic [POS_W-1:0]  pos;
        logic              last_white;

        hit_t expected_hits[$];
        int   errors;

        function void clear_scan();
            state      = ST_LEAD;
            flips      = '0;
            run_cur    = '0;
            run_prev   = '0;
            pat_start  = '0;
            pat_end    = '0;
            pos        = '0;
            last_white = 1'b0;
        endfunction

        function void power_up();
            ratio_num  = RATIO_NUM_RST;
            ratio_den  = RATIO_DEN_RST;
            ring_flips = RING_FLIPS_RST;
            errors     = 0;
            expected_hits.delete();
            clear_scan();
        endfunction

        function void set_config(int num, int den, int flp);
            ratio_num  = NUM_W'(num);
            ratio_den  = DEN_W'(den);
            ring_flips = FLIP_W'(flp);
        endfunction

        function logic [PAT_W-1:0] clamp_col(int unsigned p);
            return (p > MAX_LINE - 1) ? PAT_W'(MAX_LINE - 1) : PAT_W'(p);
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction

        function void note_pixel(pix_item_t p);
            int unsigned i, mx, sum, half, center, hx, hy;
            bit          bal, unbal;
            hit_t        h;
            if (p.line_start) begin
                clear_scan();
                last_white = p.pixel_white;
            end
            i = pos;
            if (p.pixel_white == last_white && run_cur < 8191)
                run_cur = run_cur + 1'b1;
            last_white = p.pixel_white;

            mx    = (run_cur > run_prev) ? run_cur : run_prev;
            sum   = run_cur + run_prev;
            bal   = (sum != 0) && (mx * ratio_den < ratio_num * sum);
            unbal = (sum != 0) && !bal;

            case (state)
                ST_LEAD: begin
                    if (p.pixel_white) begin
                        state     = ST_WHITE;
                        run_prev  = run_cur;
                        run_cur   = 1;
                        pat_start = clamp_col(i);
                    end
                end
                ST_WHITE: begin
                    if (!p.pixel_white) begin
                        if (run_cur < run_prev) begin
                            state = ST_RING_B;
                            flips = 1;
                        end else begin
                            state = ST_LEAD;
                        end
                        run_prev = run_cur;
                        run_cur  = 1;
                    end
                end
                ST_RING_B: begin
                    if (p.pixel_white) begin
                        run_prev = run_cur;
                        run_cur  = 1;
                        if (bal) begin
                            state = ST_RING_W;
                            flips = flips + 1'b1;
                        end else begin
                            state = ST_WHITE;
                        end
                    end else if (run_cur > run_prev && unbal) begin
                        state = ST_LEAD;
                    end
                end
                ST_RING_W: begin
                    if (!p.pixel_white) begin
                        pat_end  = clamp_col((i == 0) ? 0 : i - 1);
                        run_prev = run_cur;
                        run_cur  = 1;
                        if (bal) begin
                            if (flips == ring_flips) begin
                                state = ST_FINAL;
                            end else begin
                                state = ST_RING_B;
                                flips = flips + 1'b1;
                            end
                        end else begin
                            state = ST_LEAD;
                        end
                    end else if (run_cur > run_prev && unbal) begin
                        state = ST_WHITE;
                    end
                end
                ST_FINAL: begin
                    if (p.pixel_white) begin
                        if (run_cur < run_prev) begin
                            state = ST_LEAD;
                        end else begin
                            half   = (pat_end >= pat_start) ? (pat_end - pat_start) / 2 : 0;
                            center = pat_start + half;
                            hx     = p.horizontal ? center + p.x_offset : p.x_offset;
                            hy     = p.horizontal ? p.y_offset : center + p.y_offset;
                            h.valid          = 1'b1;
                            h.hit_x          = HIT_W'(hx);
                            h.hit_y          = HIT_W'(hy);
                            h.ring_size      = SIZE_W'(half);
                            h.hit_horizontal = p.horizontal;
                            expected_hits = {expected_hits, h};
                        end
                    end else if (run_cur > run_prev && unbal) begin
                        state = ST_LEAD;
                    end
                end
                default: begin
                    state = ST_LEAD;
                end
            endcase

            pos = (i < MAX_LINE) ? POS_W'(i + 1) : POS_W'(MAX_LINE);
        endfunction

        function void check_hit(hit_t got);
            hit_t want;
            if (expected_hits.size() == 0) begin
                $error("unexpected hit: x %0d y %0d size %0d horizontal %0d",
                       got.hit_x, got.hit_y, got.ring_size, got.hit_horizontal);
                errors++;
                return;
            end
            want = expected_hits.pop_front();
            if (got.hit_x != want.hit_x) begin
                $error("hit_x: expected %0d, actual %0d", want.hit_x, got.hit_x);
                errors++;
            end
            if (got.hit_y != want.hit_y) begin
                $error("hit_y: expected %0d, actual %0d", want.hit_y, got.hit_y);
                errors++;
            end
            if (got.ring_size != want.ring_size) begin
                $error("ring_size: expected %0d, actual %0d", want.ring_size, got.ring_size);
                errors++;
            end
            if (got.hit_horizontal != want.hit_horizontal) begin
                $error("hit_horizontal: expected %0d, actual %0d",
                       want.hit_horizontal, got.hit_horizontal);
                errors++;
            end
        endfunction
    endclass

    localparam int NUM_PHASES = 9;
    localparam int PHASE_ITEMS = 115;
    localparam int PHASE_CFG [NUM_PHASES][3] = '{
        '{18, 25, 8}, '{63, 1, 2}, '{1, 63, 4}, '{63, 63, 14}, '{40, 63, 6},
        '{1, 1, 15}, '{36, 50, 1}, '{45, 60, 10}, '{18, 25, 8}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_RATIO_NUM;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;  // pixel_white, x_offset, y_offset
    logic [1:0]            s_tuser   = '0;  // line_start, horizontal
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;         // hit_x, hit_y, ring_size
    logic [0:0]            m_tuser;         // hit_horizontal

    run_hit_scoreboard sb = new;
    int items_sent = 0;
    int hits_taken = 0;
    int tx_quiet   = 0;

    nested_ring_run_scanner i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            quiet = $urandom_range(20, 80);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_pixel(input pix_item_t p);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, p.y_offset, p.x_offset, p.pixel_white};
        s_tuser  <= {p.horizontal, p.line_start};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_pixel(p);
        items_sent++;
    endtask

    // Runs alternate black and white, starting with black.
    task automatic send_line(input int runs[$], input bit hz, input bit with_start,
                             input int ox, input int oy);
        pix_item_t p;
        bit        first;
        first = with_start;
        foreach (runs[k]) begin
            repeat (runs[k]) begin
                p.line_start  = first;
                p.pixel_white = k % 2;
                p.x_offset    = (ox < 0) ? OFS_W'($urandom_range(0, 4095)) : OFS_W'(ox);
                p.y_offset    = (oy < 0) ? OFS_W'($urandom_range(0, 4095)) : OFS_W'(oy);
                p.horizontal  = hz;
                first = 1'b0;
                push_pixel(p);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic apply_config(input int num, input int den, input int flp);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RATIO_NUM;
        cfg_data  <= CFG_DATA_W'(num);
        @(posedge aclk);
        cfg_index <= CFG_RATIO_DEN;
        cfg_data  <= CFG_DATA_W'(den);
        @(posedge aclk);
        cfg_index <= CFG_RING_FLIPS;
        cfg_data  <= CFG_DATA_W'(flp);
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_config(num, den, flp);
    endtask

    function automatic int jitter(int base);
        int j, len;
        j   = $urandom_range(0, 2);
        len = base + j - 1;
        return (len < 1) ? 1 : len;
    endfunction

    task automatic run_random(input int quota);
        int        stop_at, r, base, pairs, j, n;
        int        runs[$];
        pix_item_t p;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                base  = $urandom_range(1, 6);
                j     = $urandom_range(0, 2);
                pairs = int'(sb.ring_flips) / 2 + j - 1;
                runs  = {};
                runs  = {runs, base + int'($urandom_range(1, 3))};
                runs  = {runs, base};
                repeat (pairs) begin
                    runs = {runs, jitter(base)};
                    runs = {runs, jitter(base)};
                end
                runs = {runs, jitter(base)};
                runs = {runs, base + int'($urandom_range(0, 3))};
                runs = {runs, int'($urandom_range(1, 3))};
                // break the signature in one run
                if (r >= 70)
                    runs[$urandom_range(0, runs.size() - 1)] = $urandom_range(1, 20);
                send_line(runs, $urandom_range(0, 1), $urandom_range(0, 19) != 0, -1, -1);
            end else begin
                n = $urandom_range(5, 40);
                repeat (n) begin
                    p.line_start  = ($urandom_range(0, 15) == 0);
                    p.pixel_white = $urandom_range(0, 1);
                    p.x_offset    = $urandom_range(0, 4095);
                    p.y_offset    = $urandom_range(0, 4095);
                    p.horizontal  = $urandom_range(0, 1);
                    push_pixel(p);
                end
            end
        end
    endtask

    always @(posedge aclk) begin : hit_monitor
        hit_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.valid          = 1'b1;
            got.hit_x          = m_tdata[12:0];
            got.hit_y          = m_tdata[25:13];
            got.ring_size      = m_tdata[36:26];
            got.hit_horizontal = m_tuser[0];
            sb.check_hit(got);
            hits_taken++;
        end
    end

    initial begin : hit_sink
        int hold;
        int quiet;
        bit pressed;
        hold    = 0;
        quiet   = 0;
        pressed = 1'b0;
        forever begin
            @(posedge aclk);
            // hold off long enough for the block to back up its input
            if (!pressed && hits_taken >= 30) begin
                pressed = 1'b1;
                hold    = 400;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                hold = pick_gap(quiet);
            end
        end
    end

    initial begin : timeout
        #50_000_000;
        $display("tb_nested_ring_run_scanner: FAIL");
        $finish;
    end

    initial begin : stimulus
        sb.power_up();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_line('{2, 1, 1}, 1'b1, 1'b0, 100, 200);

        apply_config(18, 25, 2);
        send_line('{3, 2, 2, 2, 2, 3}, 1'b1, 1'b1, 4095, 4095);
        send_line('{3, 2, 2, 2, 2, 3, 1}, 1'b0, 1'b1, 0, 0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            apply_config(PHASE_CFG[ph][0], PHASE_CFG[ph][1], PHASE_CFG[ph][2]);
            run_random(PHASE_ITEMS);
        end

        drain();
        repeat (10) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d expected hits never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb_nested_ring_run_scanner: PASS");
        else
            $display("tb_nested_ring_run_scanner: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
sv/nrrs_pkg.sv
sv/nrrs_scan.sv
sv/nested_ring_run_scanner.sv
tb/tb_nested_ring_run_scanner.sv
